@@ hdl/ats_pkg.sv @@
// ----------------------------------------------------------------------------
// ats_pkg
// Shared types, constants and helpers for the article text statistics block.
// ----------------------------------------------------------------------------
package ats_pkg;

  localparam int CNT_W    = 32;
  localparam int OUT_W    = 32;
  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = $clog2(Q_DEPTH);

  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [2:0] LEN_MAX = 3'd5;
  localparam logic [2:0] MARK_LEN = 3'd4;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       close_line;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] letter_count;
    logic [OUT_W-1:0] word_count;
    logic [OUT_W-1:0] sentence_count;
    logic [OUT_W-1:0] paragraph_count;
  } out_t;

  // classified byte
  typedef struct packed {
    logic take;    // byte is not a newline
    logic eol;     // line ends after this transfer
    logic digit;
    logic alpha;
    logic space;
    logic period;
    logic hash;
  } tok_t;

  typedef logic [CNT_W-1:0] cnt_t;

  function automatic cnt_t sat_inc(input cnt_t v, input logic [1:0] amt);
    logic [CNT_W:0] s;
    s = {1'b0, v} + (CNT_W+1)'(amt);
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] out_val(input cnt_t v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'(32'hFFFF_FFFF)) ? {OUT_W{1'b1}} : w[OUT_W-1:0];
  endfunction

endpackage

@@ hdl/article_text_statistics.sv @@
// ----------------------------------------------------------------------------
// article_text_statistics
// Per-article letter, word, sentence and paragraph counts over a byte stream.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle unless a stalled result fills the queue; the
//   back stage updates all counters at once. The closing line's last byte
//   passes the front token register, token queue and result register.
// Reset: synchronous, active low; clears header/article/line state and counts.
// ----------------------------------------------------------------------------
module article_text_statistics import ats_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic q_push, q_full, q_pop, q_valid;
  tok_t push_tok, q_tok;

  ats_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_tok    (push_tok),
    .q_full   (q_full)
  );

  ats_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_tok (push_tok),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_tok    (q_tok)
  );

  ats_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_tok     (q_tok),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ hdl/ats_front.sv @@
// ----------------------------------------------------------------------------
// ats_front
// Input stage: accepts bytes, classifies them into tokens for the queue.
// ----------------------------------------------------------------------------
module ats_front import ats_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic q_push,
  output tok_t q_tok,
  input  logic q_full
);

  tok_t tok_r, tok_nxt;
  logic vld_r, vld_nxt;
  logic load;

  assign q_push   = vld_r && !q_full;
  assign in_stall = vld_r && q_full;
  assign load     = in_valid && !in_stall;
  assign q_tok    = tok_r;

  always_comb begin
    tok_nxt.take   = in_data.text_byte != CH_NL;
    tok_nxt.eol    = (in_data.text_byte == CH_NL) || in_data.close_line;
    tok_nxt.digit  = (in_data.text_byte >= 8'h30) && (in_data.text_byte <= 8'h39);
    tok_nxt.alpha  = ((in_data.text_byte >= 8'h41) && (in_data.text_byte <= 8'h5A)) ||
                     ((in_data.text_byte >= 8'h61) && (in_data.text_byte <= 8'h7A));
    tok_nxt.space  = (in_data.text_byte == 8'h20) ||
                     ((in_data.text_byte >= 8'h09) && (in_data.text_byte <= 8'h0D));
    tok_nxt.period = in_data.text_byte == CH_DOT;
    tok_nxt.hash   = in_data.text_byte == CH_HASH;
    vld_nxt        = load || (vld_r && q_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (load) begin
      tok_r <= tok_nxt;
    end
  end

endmodule

@@ hdl/ats_queue.sv @@
// ----------------------------------------------------------------------------
// ats_queue
// Small token FIFO between the front and back stages.
// ----------------------------------------------------------------------------
module ats_queue import ats_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  tok_t push_tok,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output tok_t q_tok
);

  tok_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   cnt_r, cnt_nxt;

  assign full    = cnt_r == (Q_AW+1)'(Q_DEPTH);
  assign q_valid = cnt_r != '0;
  assign q_tok   = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr_r] <= push_tok;
    end
  end

endmodule

@@ hdl/ats_back.sv @@
// ----------------------------------------------------------------------------
// ats_back
// Execution stage: line and article state, saturating counters, result reg.
// ----------------------------------------------------------------------------
module ats_back import ats_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  tok_t q_tok,
  output logic q_pop,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic header_r, header_nxt;
  logic inside_r, inside_nxt;
  logic [2:0] len_r, len_nxt;
  logic hash_r, hash_nxt;
  logic nonsp_r, nonsp_nxt;
  cnt_t lwords_r, lwords_nxt;
  logic lsp_r, lsp_nxt;
  logic ldig_r, ldig_nxt;
  logic pp_r, pp_nxt;
  logic pad_r, pad_nxt;
  cnt_t letters_r, letters_nxt;
  cnt_t words_r, words_nxt;
  cnt_t sent_r, sent_nxt;
  cnt_t para_r, para_nxt;
  logic content_r, content_nxt;
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  logic in_take, alnum, sent_a1, pp1, pad1, content1, word_start, nonsp1, hash1, mark;
  logic art_eol, close_art, body_eol, para_inc, emit;
  logic [2:0] len1;
  logic [1:0] sent_amt;
  cnt_t letters1, sent1, para1, lwords1;
  logic [CNT_W:0] wsum;

  always_comb begin
    alnum      = q_tok.digit || q_tok.alpha;
    in_take    = q_tok.take && inside_r;
    sent_a1    = in_take && pp_r && !(pad_r && q_tok.digit);
    pp1        = in_take ? q_tok.period : pp_r;
    pad1       = (in_take && q_tok.period) ? ldig_r : pad_r;
    content1   = content_r || (in_take && alnum);
    letters1   = (in_take && alnum) ? sat_inc(letters_r, 2'd1) : letters_r;
    word_start = q_tok.take && !q_tok.space && lsp_r;
    lwords1    = word_start ? sat_inc(lwords_r, 2'd1) : lwords_r;
    nonsp1     = nonsp_r || (q_tok.take && !q_tok.space);
    len1       = (q_tok.take && len_r < LEN_MAX) ? len_r + 3'd1 : len_r;
    hash1      = hash_r && !(q_tok.take && !q_tok.hash);
    mark       = (len1 == MARK_LEN) && hash1;
    art_eol    = q_tok.eol && header_r && inside_r;
    close_art  = art_eol && mark;
    body_eol   = art_eol && !mark;
    sent_amt   = {1'b0, sent_a1} + {1'b0, body_eol && pp1};
    sent1      = sat_inc(sent_r, sent_amt);
    para_inc   = close_art ? content1 : (body_eol && !nonsp1 && content1);
    para1      = sat_inc(para_r, {1'b0, para_inc});
    wsum       = {1'b0, words_r} + {1'b0, lwords_r} + (CNT_W+1)'(word_start);
    emit       = close_art;
    q_pop      = q_valid && (!emit || !out_valid_r || !out_stall);

    header_nxt    = header_r;
    inside_nxt    = inside_r;
    len_nxt       = len_r;
    hash_nxt      = hash_r;
    nonsp_nxt     = nonsp_r;
    lwords_nxt    = lwords_r;
    lsp_nxt       = lsp_r;
    ldig_nxt      = ldig_r;
    pp_nxt        = pp_r;
    pad_nxt       = pad_r;
    letters_nxt   = letters_r;
    words_nxt     = words_r;
    sent_nxt      = sent_r;
    para_nxt      = para_r;
    content_nxt   = content_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (q_pop) begin
      letters_nxt = letters1;
      sent_nxt    = sent1;
      para_nxt    = para1;
      content_nxt = content1;
      if (q_tok.eol) begin
        header_nxt = 1'b1;
        if (header_r && !inside_r && mark) begin
          inside_nxt = 1'b1;
        end
        len_nxt    = '0;
        hash_nxt   = 1'b1;
        nonsp_nxt  = 1'b0;
        lwords_nxt = '0;
        lsp_nxt    = 1'b1;
        ldig_nxt   = 1'b0;
        pp_nxt     = 1'b0;
        pad_nxt    = 1'b0;
      end else begin
        len_nxt    = len1;
        hash_nxt   = hash1;
        nonsp_nxt  = nonsp1;
        lwords_nxt = lwords1;
        lsp_nxt    = q_tok.space;
        ldig_nxt   = q_tok.digit;
        pp_nxt     = pp1;
        pad_nxt    = pad1;
      end
      if (body_eol) begin
        words_nxt = wsum[CNT_W] ? {CNT_W{1'b1}} : wsum[CNT_W-1:0];
        if (!nonsp1 && content1) begin
          content_nxt = 1'b0;
        end
      end
      if (close_art) begin
        inside_nxt                   = 1'b0;
        out_data_nxt.letter_count    = out_val(letters1);
        out_data_nxt.word_count      = out_val(words_r);
        out_data_nxt.sentence_count  = out_val(sent1);
        out_data_nxt.paragraph_count = out_val(para1);
        out_valid_nxt                = 1'b1;
        letters_nxt                  = '0;
        words_nxt                    = '0;
        sent_nxt                     = '0;
        para_nxt                     = '0;
        content_nxt                  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r    <= 1'b0;
      inside_r    <= 1'b0;
      len_r       <= '0;
      hash_r      <= 1'b1;
      nonsp_r     <= 1'b0;
      lwords_r    <= '0;
      lsp_r       <= 1'b1;
      ldig_r      <= 1'b0;
      pp_r        <= 1'b0;
      pad_r       <= 1'b0;
      letters_r   <= '0;
      words_r     <= '0;
      sent_r      <= '0;
      para_r      <= '0;
      content_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      header_r    <= header_nxt;
      inside_r    <= inside_nxt;
      len_r       <= len_nxt;
      hash_r      <= hash_nxt;
      nonsp_r     <= nonsp_nxt;
      lwords_r    <= lwords_nxt;
      lsp_r       <= lsp_nxt;
      ldig_r      <= ldig_nxt;
      pp_r        <= pp_nxt;
      pad_r       <= pad_nxt;
      letters_r   <= letters_nxt;
      words_r     <= words_nxt;
      sent_r      <= sent_nxt;
      para_r      <= para_nxt;
      content_r   <= content_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && emit) |=> out_valid_r)
    else $error("closing line did not load result register");

  a_hdr_first: assert property (@(posedge clk) disable iff (!rst_n)
    inside_r |-> header_r)
    else $error("article open before header line");

  a_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_MAX)
    else $error("line length above saturation");

  a_pp_inside: assert property (@(posedge clk) disable iff (!rst_n)
    pp_r |-> inside_r)
    else $error("period pending outside article");

endmodule

@@ test/article_text_statistics_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// article_text_statistics_tb
// Self-checking bench for the per-article text counters.
// Bytes go in over the valid/stall channel. A local tracker of the
// header/article/line state predicts the four counts for each closing
// mark, and the checker compares every result transfer with the oldest
// prediction. Directed lines cover header skipping, mark detection,
// digit-period-digit, blank lines, close_line and high bytes. Random
// articles with noise follow, with random idling on both sides.
// ----------------------------------------------------------------------------
module article_text_statistics_tb;
  import ats_pkg::*;

  localparam int STUCK_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_BYTES = 1000;
  localparam int MIN_ARTICLES = 40;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  always #10 clk = ~clk;

  article_text_statistics DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  // tracker state
  bit          header_done;
  bit          in_article;
  logic [2:0]  line_len = '0;
  bit          line_hashes = 1'b1;
  bit          line_nonblank;
  logic [31:0] line_words = '0;
  bit          prev_space = 1'b1;
  bit          prev_digit;
  bit          dot_held;
  bit          dot_after_digit;
  logic [31:0] letters = '0;
  logic [31:0] words = '0;
  logic [31:0] sentences = '0;
  logic [31:0] paragraphs = '0;
  bit          fresh_text;

  out_t expected_counts[$];
  int   errors = 0;
  int   bytes_sent = 0;
  int   stuck_cycles = 0;
  bit   no_idle = 1'b0;
  out_t want;

  function automatic logic [31:0] clamp_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic track_byte(logic [7:0] b, logic c);
    bit   is_digit, is_alpha, is_space, is_mark;
    out_t res;
    is_digit = b >= "0" && b <= "9";
    is_alpha = (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    is_space = b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    if (b != CH_NL) begin
      if (in_article) begin
        if (dot_held && !(dot_after_digit && is_digit))
          sentences = clamp_sum(sentences, 1);
        dot_held = 0;
        if (is_digit || is_alpha) begin
          letters = clamp_sum(letters, 1);
          fresh_text = 1;
        end
        if (b == CH_DOT) begin
          dot_held = 1;
          dot_after_digit = prev_digit;
        end
      end
      prev_digit = is_digit;
      if (is_space) begin
        prev_space = 1;
      end else begin
        if (prev_space)
          line_words = clamp_sum(line_words, 1);
        prev_space = 0;
        line_nonblank = 1;
      end
      if (line_len < LEN_MAX)
        line_len++;
      if (b != CH_HASH)
        line_hashes = 0;
    end
    if (b == CH_NL || c) begin
      is_mark = line_len == MARK_LEN && line_hashes;
      if (!header_done) begin
        header_done = 1;
      end else if (!in_article) begin
        if (is_mark)
          in_article = 1;
      end else if (is_mark) begin
        in_article = 0;
        if (fresh_text)
          paragraphs = clamp_sum(paragraphs, 1);
        res = '{letter_count: letters, word_count: words,
                sentence_count: sentences, paragraph_count: paragraphs};
        expected_counts.push_back(res);
        letters = 0;
        words = 0;
        sentences = 0;
        paragraphs = 0;
        fresh_text = 0;
      end else begin
        if (dot_held)
          sentences = clamp_sum(sentences, 1);
        words = clamp_sum(words, line_words);
        if (!line_nonblank && fresh_text) begin
          paragraphs = clamp_sum(paragraphs, 1);
          fresh_text = 0;
        end
      end
      line_len = 0;
      line_hashes = 1;
      line_nonblank = 0;
      line_words = 0;
      prev_space = 1;
      prev_digit = 0;
      dot_held = 0;
      dot_after_digit = 0;
    end
  endtask

  task automatic send_byte(logic [7:0] b, logic c);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 13) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = '{text_byte: b, close_line: c};
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    track_byte(b, c);
  endtask

  task automatic send_line(string s, bit close_last);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], close_last && i == s.len() - 1);
  endtask

  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 8'($urandom_range("a", "z"));
    if (r < 48) return 8'($urandom_range("A", "Z"));
    if (r < 62) return 8'($urandom_range("0", "9"));
    if (r < 74) return CH_SPACE;
    if (r < 84) return CH_DOT;
    if (r < 87) return 8'($urandom_range(CH_TAB, CH_CR));
    if (r < 91) return CH_HASH;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_random_line(int max_len);
    int len, r;
    len = $urandom_range(max_len);
    r = $urandom_range(99);
    for (int i = 0; i < len; i++)
      send_byte(pick_text_byte(), r < 12 && i == len - 1);
    if (!(r < 12 && len > 0))
      send_byte(CH_NL, r > 94);
  endtask

  task automatic send_mark();
    if ($urandom_range(9) == 0)
      send_line("####", 1);
    else if ($urandom_range(9) == 0)
      send_line("####\n", 1);
    else
      send_line("####\n", 0);
  endtask

  // header line is skipped even when it looks like a mark
  task automatic test_header_skip();
    send_line("####\n", 0);
    send_line("x. 1.2\n", 0);
    send_line("###\n", 0);
  endtask

  task automatic test_marked_text();
    send_line("####\n", 0);
    send_line("Ab 3.5 x.y\n", 0);
    send_line(" \t\r\n", 0);
    send_line(".q 7.\n", 0);
    send_byte(8'hFF, 0);
    send_byte(8'h80, 0);
    send_byte(8'h00, 0);
    send_byte(8'h7F, 0);
    send_byte(CH_NL, 0);
    send_line("#####\n##x#\n\n", 0);
    send_line("####", 1);
  endtask

  task automatic test_line_close();
    send_line("####", 1);
    send_line("end.", 1);
    send_byte(CH_NL, 1);
    send_line("9.9\n", 0);
    send_line("####", 0);
    send_byte(CH_NL, 1);
    send_line("####\n####\n", 0);
  endtask

  task automatic test_random_articles();
    int start, lines, r;
    start = bytes_sent;
    for (int a = 0; bytes_sent - start < RANDOM_BYTES || a < MIN_ARTICLES; a++) begin
      no_idle = a >= 8 && a < 16;
      if ($urandom_range(99) < 15)
        send_random_line(12);
      if ($urandom_range(99) >= 5)
        send_mark();
      lines = $urandom_range(1, 5);
      for (int k = 0; k < lines; k++) begin
        r = $urandom_range(99);
        if (r < 15)
          send_byte(CH_NL, 0);
        else if (r < 20)
          send_line(" \n", 0);
        else if (r < 25)
          send_line($urandom_range(1) ? "###\n" : "#####\n", 0);
        else
          send_random_line(16);
      end
      if ($urandom_range(99) >= 5)
        send_mark();
    end
    no_idle = 1'b0;
  endtask

  always @(negedge clk)
    out_stall <= !no_idle && $urandom_range(99) < 13;

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_counts.size() == 0) begin
        $display("%0t ns: result transfer with none expected, got %h", $time, out_data);
        errors++;
      end else begin
        want = expected_counts.pop_front();
        check_field("letter_count", want.letter_count, out_data.letter_count);
        check_field("word_count", want.word_count, out_data.word_count);
        check_field("sentence_count", want.sentence_count, out_data.sentence_count);
        check_field("paragraph_count", want.paragraph_count, out_data.paragraph_count);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t ns: timeout, %0d results outstanding", $time, expected_counts.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_header_skip();
    test_marked_text();
    test_line_close();
    test_random_articles();
    @(negedge clk);
    in_valid = 1'b0;
    wait (expected_counts.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/ats_pkg.sv
hdl/ats_front.sv
hdl/ats_queue.sv
hdl/ats_back.sv
hdl/article_text_statistics.sv
test/article_text_statistics_tb.sv
